// ===== sv/byte_ring_queue_with_pattern_find_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the byte ring queue
// Shared property forms used by the checker of the byte ring queue.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_QUEUE_WITH_PATTERN_FIND_MACROS_SVH
`define BYTE_RING_QUEUE_WITH_PATTERN_FIND_MACROS_SVH

// A stalled transfer keeps valid high and its data unchanged
`define BRQ_ASSERT_HOLD(label, clk, rst_n, valid, ready, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (valid && !ready) |=> (valid && $stable(data))) \
        else $error("stalled transfer changed");

// Same-cycle implication
`define BRQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("result check failed");

`endif

// ===== sv/brq_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte ring queue package
// Types, codes and widths shared by the byte ring queue modules.
// ----------------------------------------------------------------------------
package brq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int BYTE_BITS       = 8;
    localparam int PAT_BITS        = 64;
    localparam int LEN_BITS        = 4;
    localparam int KIND_BITS       = 2;
    localparam int S_TDATA_W       = 80;
    localparam int M_TDATA_W       = 24;
    localparam int OPQ_DEPTH       = 2;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_FIND  = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP,
        BK_FIND
    } back_state_t;

    // Decoded operation, front to back; pattern stored last byte first
    typedef struct packed {
        kind_t                 kind;
        logic [BYTE_BITS-1:0]  push_byte;
        logic [PAT_BITS-1:0]   pattern_rev;
        logic [LEN_BITS-1:0]   len;
    } brq_op_t;

    // Result item, popped_byte in the low bits
    typedef struct packed {
        logic [BYTE_BITS-1:0]  fill_level;
        status_t               status;
        logic [BYTE_BITS-1:0]  popped_byte;
    } brq_result_t;

endpackage

// ===== sv/byte_ring_queue_with_pattern_find.sv =====
// ----------------------------------------------------------------------------
// Byte ring queue with pattern find
// Circular byte queue with push, pop, clear and substring search.
// ----------------------------------------------------------------------------
// Usage:
//   One input transfer on s_* (s_tuser = kind) yields one result transfer on
//   m_*, in order.
//   Push, clear and ops rejected at once (full, empty, bad length): result
//   valid after the op passes the op queue and the result register, one per
//   cycle back to back while m_tready is high. Pop: the byte store has a
//   registered read port, so the result also passes BK_POP. Find: reads
//   one held byte per cycle, stops at a match; later ops wait in op queue.
//   A two-entry op queue between decode and sequencer takes two more
//   transfers while a result waits; then s_tready drops. When the receiver
//   stalls, the result register holds and the sequencer waits.
//   Reset empties the queue (both pointers to zero) and clears all valids.
//   The store holds at most QUEUE_DEPTH-1 bytes; fill_level saturates at 255.
// ----------------------------------------------------------------------------
module byte_ring_queue_with_pattern_find #(
    parameter int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF,
    parameter int PATTERN_MAX = brq_pkg::PATTERN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // push_byte[7:0], pattern_bytes[71:8], pattern_length[75:72], zero pad
    input  logic [brq_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [brq_pkg::KIND_BITS-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // popped_byte[7:0], status[9:8], fill_level[17:10], zero pad
    output logic [brq_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic             q_valid;
    logic             q_pop;
    brq_pkg::brq_op_t q_op;

    brq_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_brq_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop)
    );

    brq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_brq_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_op     (q_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/brq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/brq_front.sv =====
// ----------------------------------------------------------------------------
// Byte ring queue front end
// Accepts input transfers, decodes them and holds them in a short op queue.
// ----------------------------------------------------------------------------
module brq_front #(
    parameter int PATTERN_MAX = brq_pkg::PATTERN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [brq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [brq_pkg::KIND_BITS-1:0]  s_tuser,
    output logic                           q_valid,
    output brq_pkg::brq_op_t               q_op,
    input  logic                           q_pop
);

    localparam int LB = brq_pkg::LEN_BITS;

    brq_pkg::brq_op_t     op_mem_reg [brq_pkg::OPQ_DEPTH];
    brq_pkg::brq_op_t     dec_op;
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 accept;
    logic [LB-1:0]        len_raw;
    logic [LB-1:0]        len_c;
    logic [brq_pkg::PAT_BITS-1:0] pat;

    // Decode: clamp length, reverse pattern so byte j matches the byte j back
    always_comb
    begin
        len_raw = s_tdata[75:72];
        pat     = s_tdata[71:8];
        len_c   = (len_raw > LB'(PATTERN_MAX)) ? LB'(PATTERN_MAX) : len_raw;
        dec_op             = '0;
        dec_op.kind        = brq_pkg::kind_t'(s_tuser);
        dec_op.push_byte   = s_tdata[7:0];
        dec_op.len         = len_c;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (i + j + 1 == int'(len_c))
                begin
                    dec_op.pattern_rev[j*8 +: 8] = pat[i*8 +: 8];
                end
            end
        end
    end

    // Op queue control
    assign s_tready = (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_op     = op_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, accept} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Op queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mem_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

// ===== sv/brq_back.sv =====
// ----------------------------------------------------------------------------
// Byte ring queue back end
// Executes queued ops on the byte store and drives the result register.
// ----------------------------------------------------------------------------
module brq_back #(
    parameter int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF,
    parameter int PATTERN_MAX = brq_pkg::PATTERN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  brq_pkg::brq_op_t               q_op,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brq_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int LB = brq_pkg::LEN_BITS;

    brq_pkg::back_state_t state_reg, state_next;
    logic [PW-1:0]        rp_reg, rp_next;
    logic [PW-1:0]        wp_reg, wp_next;
    logic [PW-1:0]        count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    brq_pkg::brq_result_t res_reg, res_next;
    logic [PW-1:0]        rd_addr_reg, rd_addr_next;
    logic [PW-1:0]        issue_left_reg, issue_left_next;
    logic                 pending_reg, pending_next;
    logic [LB-1:0]        got_reg, got_inc;
    logic [LB-1:0]        len_reg;
    logic [7:0]           win_reg [PATTERN_MAX];
    logic [7:0]           win_next [PATTERN_MAX];
    logic [7:0]           pat_reg [PATTERN_MAX];
    logic                 res_load;
    logic                 take;
    logic                 out_free;
    logic                 full, empty, len_zero, too_long;
    logic                 hit, find_done;
    logic                 ram_wr_en, ram_rd_en;
    logic [PW-1:0]        ram_rd_addr;
    logic [7:0]           ram_rd_data;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] fill_of(input logic [PW-1:0] c);
        return ({8'd0, c} > (PW + 8)'(255)) ? 8'hFF : 8'(c);
    endfunction

    brq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_brq_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (q_op.push_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Condition flags
    assign out_free = !out_valid_reg || m_tready;
    assign take     = (state_reg == brq_pkg::BK_IDLE) && q_valid && out_free;
    assign full     = (count_reg == PW'(QUEUE_DEPTH - 1));
    assign empty    = (count_reg == '0);
    assign len_zero = (q_op.len == '0);
    assign too_long = ((PW + LB)'(q_op.len) > (PW + LB)'(count_reg));

    // Pattern window: newest byte at index 0
    always_comb
    begin
        win_next[0] = ram_rd_data;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
        got_inc = (got_reg == LB'(PATTERN_MAX)) ? got_reg : got_reg + 1'b1;
        hit = (got_inc >= len_reg);
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((LB'(j) < len_reg) && (win_next[j] != pat_reg[j]))
            begin
                hit = 1'b0;
            end
        end
        find_done = pending_reg && (hit || (issue_left_reg == '0));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brq_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    case (q_op.kind)
                        brq_pkg::KIND_POP:
                        begin
                            if (!empty)
                            begin
                                state_next = brq_pkg::BK_POP;
                            end
                        end
                        brq_pkg::KIND_FIND:
                        begin
                            if (!len_zero && !too_long)
                            begin
                                state_next = brq_pkg::BK_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = brq_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            brq_pkg::BK_POP:
            begin
                state_next = brq_pkg::BK_IDLE;
            end
            brq_pkg::BK_FIND:
            begin
                if (find_done)
                begin
                    state_next = brq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = brq_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        q_pop           = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rp_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        res_load        = 1'b0;
        res_next        = res_reg;
        rd_addr_next    = rd_addr_reg;
        issue_left_next = issue_left_reg;
        pending_next    = 1'b0;
        case (state_reg)
            brq_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    q_pop                = 1'b1;
                    res_next.popped_byte = 8'd0;
                    res_next.status      = brq_pkg::STATUS_OK;
                    res_next.fill_level  = fill_of(count_reg);
                    case (q_op.kind)
                        brq_pkg::KIND_PUSH:
                        begin
                            res_load = 1'b1;
                            if (full)
                            begin
                                res_next.status = brq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_wr_en           = 1'b1;
                                wp_next             = adv(wp_reg);
                                count_next          = count_reg + 1'b1;
                                res_next.fill_level = fill_of(count_reg + 1'b1);
                            end
                        end
                        brq_pkg::KIND_POP:
                        begin
                            if (empty)
                            begin
                                res_load        = 1'b1;
                                res_next.status = brq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_rd_en  = 1'b1;
                                rp_next    = adv(rp_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        brq_pkg::KIND_CLEAR:
                        begin
                            res_load            = 1'b1;
                            rp_next             = wp_reg;
                            count_next          = '0;
                            res_next.fill_level = 8'd0;
                        end
                        default:
                        begin
                            if (len_zero || too_long)
                            begin
                                res_load        = 1'b1;
                                res_next.status = brq_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr_next    = rp_reg;
                                issue_left_next = count_reg;
                            end
                        end
                    endcase
                end
            end
            brq_pkg::BK_POP:
            begin
                res_load             = 1'b1;
                res_next.popped_byte = ram_rd_data;
                res_next.status      = brq_pkg::STATUS_OK;
                res_next.fill_level  = fill_of(count_reg);
            end
            brq_pkg::BK_FIND:
            begin
                // One stored byte read per cycle
                if (issue_left_reg != '0)
                begin
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = rd_addr_reg;
                    rd_addr_next    = adv(rd_addr_reg);
                    issue_left_next = issue_left_reg - 1'b1;
                    pending_next    = 1'b1;
                end
                if (find_done)
                begin
                    res_load             = 1'b1;
                    res_next.popped_byte = 8'd0;
                    res_next.status      = hit ? brq_pkg::STATUS_OK
                                               : brq_pkg::STATUS_NOT_FOUND;
                    res_next.fill_level  = fill_of(count_reg);
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
        out_valid_next = res_load || (out_valid_reg && !m_tready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brq_pkg::BK_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            issue_left_reg <= '0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            issue_left_reg <= issue_left_next;
            pending_reg    <= pending_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        rd_addr_reg <= rd_addr_next;
        if (take && (q_op.kind == brq_pkg::KIND_FIND))
        begin
            len_reg <= q_op.len;
            got_reg <= '0;
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                pat_reg[j] <= q_op.pattern_rev[j*8 +: 8];
            end
        end
        else if ((state_reg == brq_pkg::BK_FIND) && pending_reg)
        begin
            got_reg <= got_inc;
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg};

endmodule

// ===== sv/brq_checker.sv =====
// ----------------------------------------------------------------------------
// Byte ring queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_ring_queue_with_pattern_find_macros.svh"

module brq_checker #(
    parameter int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [brq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [7:0] FILL_MAX = (QUEUE_DEPTH - 1 > 255) ? 8'd255
                                                             : 8'(QUEUE_DEPTH - 1);

    logic [7:0] res_popped;
    logic [1:0] res_status;
    logic [7:0] res_fill;

    // Result fields
    assign res_popped = m_tdata[7:0];
    assign res_status = m_tdata[9:8];
    assign res_fill   = m_tdata[17:10];

    // Result holds while stalled
    `BRQ_ASSERT_HOLD(a_m_hold, clk, rst_n, m_tvalid, m_tready, m_tdata)

    // Fill never exceeds capacity
    `BRQ_ASSERT_IMPL(a_fill_max, clk, rst_n, m_tvalid, res_fill <= FILL_MAX)

    // Pop on empty reports an empty queue and no byte
    `BRQ_ASSERT_IMPL(a_empty_pop, clk, rst_n, m_tvalid && (res_status == brq_pkg::STATUS_EMPTY), (res_fill == 8'd0) && (res_popped == 8'd0))

    // Dropped push only when the queue is at capacity
    `BRQ_ASSERT_IMPL(a_full_push, clk, rst_n, m_tvalid && (res_status == brq_pkg::STATUS_FULL), res_fill == FILL_MAX)

endmodule

bind byte_ring_queue_with_pattern_find brq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_brq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
